/* design/motor_frame_bridge_macros.svh */
// Assertion macros shared by the motor frame bridge modules.
`ifndef MOTOR_FRAME_BRIDGE_MACROS_SVH
`define MOTOR_FRAME_BRIDGE_MACROS_SVH
// Same-cycle implication, gated off during reset.
`define MFB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, gated off during reset.
`define MFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* design/mfb_pkg.sv */
// Types, constants and helper functions of the motor frame bridge.
package mfb_pkg;
	localparam int MOTOR_COUNT = 40;
	localparam int HALF_COUNT  = 20;
	localparam int FRAME_LEN   = 20;

	localparam logic [7:0] HDR1_BYTE  = 8'hAA;
	localparam logic [7:0] HDR2_BYTE  = 8'hBB;
	localparam logic [7:0] FOOT1_BYTE = 8'hCC;
	localparam logic [7:0] FOOT2_BYTE = 8'hDD;
	localparam logic [7:0] OUT_START  = 8'h68;
	localparam logic [7:0] OUT_END    = 8'h16;

	localparam logic [9:0]  ELAPSED_MAX    = 10'd1023;
	localparam logic [9:0]  MIN_GAP_RST    = 10'd35;
	localparam logic [9:0]  REPEAT_GAP_RST = 10'd120;
	localparam logic [15:0] PULSE_RST      = 16'd150;

	// x/100 == (x*5243) >> 19 for every x below 43699.
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;

	typedef enum logic [1:0] {
		REG_MIN_GAP    = 2'd0,
		REG_REPEAT_GAP = 2'd1,
		REG_PULSE      = 2'd2,
		REG_NONE       = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_HUNT, PH_HDR2, PH_DATA, PH_CHECK, PH_FOOT1, PH_FOOT2_OK, PH_FOOT2_BAD
	} phase_t;

	typedef enum logic [1:0] {
		CMD_STAGE, CMD_COMMIT, CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [5:0]  idx;
		logic [7:0]  data;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_SCAN, BK_DECIDE, BK_MUL, BK_DIV, BK_COPY, BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic [9:0]  min_gap;
		logic [9:0]  repeat_gap;
		logic [15:0] pulse;
	} cfg_t;

	// Gate mask bit of one motor within its half.
	function automatic logic [15:0] gate_bit(input logic [4:0] k);
		logic [2:0] pair;
		pair = k[4:2];
		gate_bit = k[0] ? (16'h0400 >> pair) : (16'h8000 >> pair);
	endfunction

	function automatic logic [7:0] frame_at(
		input logic [4:0]  pos,
		input logic [15:0] pulse,
		input logic [7:0]  inten,
		input logic [15:0] g1,
		input logic [15:0] g2,
		input logic [15:0] g3,
		input logic [15:0] g4
	);
		case (pos)
			5'd0, 5'd1: frame_at = OUT_START;
			5'd2, 5'd3: frame_at = 8'h01;
			5'd7:       frame_at = pulse[15:8];
			5'd8:       frame_at = pulse[7:0];
			5'd9, 5'd10: frame_at = inten;
			5'd11:      frame_at = g1[15:8];
			5'd12:      frame_at = g1[7:0];
			5'd13:      frame_at = g2[15:8];
			5'd14:      frame_at = g2[7:0];
			5'd15:      frame_at = g3[15:8];
			5'd16:      frame_at = g3[7:0];
			5'd17:      frame_at = g4[15:8];
			5'd18:      frame_at = g4[7:0];
			5'd19:      frame_at = OUT_END;
			default:    frame_at = 8'h00;
		endcase
	endfunction
endpackage

/* design/motor_frame_bridge.sv */
// Top level of the motor frame bridge: deframer, command queue and frame sender.
//
// Input channel (in_valid / in_stall): each transaction is either a received
// serial byte (operation 0, rx_byte) or a one millisecond tick (operation 1,
// link_up). The front end deframes each byte as it is accepted; a good
// level frame becomes a commit command that swaps the level banks.
// Output channel (out_valid / out_stall): 20-byte vibration frames, one byte
// per transaction, frame_last marking byte 19.
// The back end writes each staged byte as it pops it. A tick that passes the
// link, pending and min_gap checks scans the 40 levels and decides; if a frame
// is due it computes intensity in a multiply and a divide state, copies the
// levels to the sent bank and emits 20 bytes.
// The level bank memory ports pace the scan and the copy, one entry a cycle.
// in_stall rises only when the command queue is full. The back end pops only
// when idle, so while a frame is built bytes queue up until the queue fills.
// A stalled receiver holds the current byte; the back end waits in its emit
// state and the queue absorbs new input until it fills.
// Reset clears the parser, queue, pending flag, elapsed count and the level
// valid bits, so stored and sent levels read as zero; registers return to
// min_gap 35, repeat_gap 120, pulse 150. Write configuration only when idle.
module motor_frame_bridge #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  rx_byte,
	input  logic        link_up,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        frame_last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mfb_pkg::*;

	cfg_t cfg_q;
	cmd_t push_cmd, head;
	logic push, pop, q_full, q_empty;

	// Configuration registers; index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_gap    <= MIN_GAP_RST;
			cfg_q.repeat_gap <= REPEAT_GAP_RST;
			cfg_q.pulse      <= PULSE_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MIN_GAP:    cfg_q.min_gap    <= cfg_data[9:0];
				REG_REPEAT_GAP: cfg_q.repeat_gap <= cfg_data[9:0];
				REG_PULSE:      cfg_q.pulse      <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// Front: accept and classify every input transaction.
	mfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.rx_byte  (rx_byte),
		.link_up  (link_up),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	// Short command queue decouples parsing from frame sending.
	mfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Back: level banks, pacing and the output register.
	mfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_byte(frame_byte),
		.frame_last(frame_last)
	);
endmodule

/* design/mfb_front.sv */
// Front end: accepts input transactions, deframes bytes and issues commands.
module mfb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          operation,
	input  logic [7:0]    rx_byte,
	input  logic          link_up,
	input  logic          q_full,
	output logic          push,
	output mfb_pkg::cmd_t cmd
);
	import mfb_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic [5:0] count_q, count_nxt;
	logic [7:0] xor_q, xor_nxt;
	logic [7:0] check_q, check_nxt;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		phase_nxt = phase_q;
		count_nxt = count_q;
		xor_nxt   = xor_q;
		check_nxt = check_q;
		push      = 1'b0;
		cmd.kind  = CMD_TICK;
		cmd.idx   = count_q;
		cmd.data  = {7'd0, link_up};
		if (accept && operation) begin
			push = 1'b1;
		end else if (accept) begin
			cmd.data = rx_byte;
			case (phase_q)
				PH_HDR2: begin
					if (rx_byte == HDR2_BYTE) begin
						phase_nxt = PH_DATA;
						count_nxt = 6'd0;
						xor_nxt   = 8'd0;
					end else begin
						phase_nxt = PH_HUNT;
					end
				end
				PH_DATA: begin
					push      = 1'b1;
					cmd.kind  = CMD_STAGE;
					xor_nxt   = xor_q ^ rx_byte;
					count_nxt = count_q + 6'd1;
					if (count_q == 6'(MOTOR_COUNT - 1)) begin
						phase_nxt = PH_CHECK;
					end
				end
				PH_CHECK: begin
					check_nxt = rx_byte;
					phase_nxt = PH_FOOT1;
				end
				PH_FOOT1: begin
					phase_nxt = (rx_byte == FOOT1_BYTE) ? PH_FOOT2_OK : PH_FOOT2_BAD;
				end
				PH_FOOT2_OK: begin
					if (rx_byte == FOOT2_BYTE && xor_q == check_q) begin
						push     = 1'b1;
						cmd.kind = CMD_COMMIT;
					end
					phase_nxt = PH_HUNT;
				end
				PH_FOOT2_BAD: begin
					phase_nxt = PH_HUNT;
				end
				default: begin
					phase_nxt = (rx_byte == HDR1_BYTE) ? PH_HDR2 : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= 6'd0;
			xor_q   <= 8'd0;
			check_q <= 8'd0;
		end else begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
			xor_q   <= xor_nxt;
			check_q <= check_nxt;
		end
	end
endmodule

/* design/mfb_queue.sv */
// Command queue between the front end and the back end.
`include "motor_frame_bridge_macros.svh"
module mfb_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mfb_pkg::cmd_t push_cmd,
	input  logic          pop,
	output mfb_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import mfb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t        slot_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	`MFB_ASSERT_SAME(a_no_overflow, full, !push, "push into a full command queue")
endmodule

/* design/mfb_back.sv */
// Back end: level banks, tick pacing, frame build and output register.
`include "motor_frame_bridge_macros.svh"
module mfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mfb_pkg::cfg_t cfg,
	input  mfb_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    frame_byte,
	output logic          frame_last
);
	import mfb_pkg::*;

	back_state_t state_q, state_nxt;
	logic [5:0]  cnt_q;
	logic        sel_q, pending_q;
	logic [9:0]  elapsed_q, elapsed_n;
	logic        changed_q, nonzero_q, send;
	logic [7:0]  max_q, inten_q;
	logic [15:0] g1_q, g2_q, g3_q, g4_q, prod_q;
	logic [28:0] quot_full;
	logic [4:0]  emit_q;
	logic        ov_q, last_q, out_ready, tick_go;
	logic [7:0]  byte_q;

	logic [7:0]  bank0_mem [MOTOR_COUNT];
	logic [7:0]  bank1_mem [MOTOR_COUNT];
	logic [7:0]  sent_mem  [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] v0_q, v1_q, vs_q;
	logic [7:0]  rd0_q, rd1_q, rds_q;
	logic        rv0_q, rv1_q, rvs_q;
	logic [5:0]  rd_addr, pi;
	logic [4:0]  k;
	logic [7:0]  cur_val, sent_val;
	logic        stage_wr, proc_ok, copy_wr;

	assign pop       = (state_q == BK_IDLE) && !q_empty;
	assign elapsed_n = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 10'd1;
	assign tick_go   = (head.kind == CMD_TICK) && head.data[0] && pending_q
		&& (elapsed_n >= cfg.min_gap);
	assign send      = changed_q || (nonzero_q && (elapsed_q >= cfg.repeat_gap));
	assign out_ready = !ov_q || !out_stall;
	assign rd_addr   = (cnt_q < 6'(MOTOR_COUNT)) ? cnt_q : 6'd0;
	assign pi        = cnt_q - 6'd1;
	assign k         = (pi >= 6'(HALF_COUNT)) ? 5'(pi - 6'(HALF_COUNT)) : pi[4:0];
	assign cur_val   = sel_q ? (rv1_q ? rd1_q : 8'd0) : (rv0_q ? rd0_q : 8'd0);
	assign sent_val  = rvs_q ? rds_q : 8'd0;
	assign stage_wr  = pop && (head.kind == CMD_STAGE);
	assign proc_ok   = (cnt_q != 6'd0);
	assign copy_wr   = (state_q == BK_COPY) && proc_ok;
	assign quot_full = 29'(prod_q) * 29'(RECIP_100);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE:   if (pop && tick_go) state_nxt = BK_SCAN;
			BK_SCAN:   if (cnt_q == 6'(MOTOR_COUNT)) state_nxt = BK_DECIDE;
			BK_DECIDE: state_nxt = send ? BK_MUL : BK_IDLE;
			BK_MUL:    state_nxt = BK_DIV;
			BK_DIV:    state_nxt = BK_COPY;
			BK_COPY:   if (cnt_q == 6'(MOTOR_COUNT)) state_nxt = BK_EMIT;
			BK_EMIT: begin
				if (out_ready && emit_q == 5'(FRAME_LEN - 1)) state_nxt = BK_IDLE;
			end
			default:   state_nxt = BK_IDLE;
		endcase
	end

	// Level memories: registered reads, one write port each.
	always_ff @(posedge clk) begin
		if (stage_wr && sel_q) begin
			bank0_mem[head.idx] <= head.data;
		end
		if (stage_wr && !sel_q) begin
			bank1_mem[head.idx] <= head.data;
		end
		if (copy_wr) begin
			sent_mem[pi] <= cur_val;
		end
		rd0_q <= bank0_mem[rd_addr];
		rd1_q <= bank1_mem[rd_addr];
		rds_q <= sent_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q  <= '0;
			v1_q  <= '0;
			vs_q  <= '0;
			rv0_q <= 1'b0;
			rv1_q <= 1'b0;
			rvs_q <= 1'b0;
		end else begin
			if (stage_wr && sel_q) v0_q[head.idx] <= 1'b1;
			if (stage_wr && !sel_q) v1_q[head.idx] <= 1'b1;
			if (copy_wr) vs_q[pi] <= 1'b1;
			rv0_q <= v0_q[rd_addr];
			rv1_q <= v1_q[rd_addr];
			rvs_q <= vs_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			cnt_q     <= 6'd0;
			sel_q     <= 1'b0;
			pending_q <= 1'b0;
			elapsed_q <= 10'd0;
			changed_q <= 1'b0;
			nonzero_q <= 1'b0;
			max_q     <= 8'd0;
			g1_q      <= 16'd0;
			g2_q      <= 16'd0;
			g3_q      <= 16'd0;
			g4_q      <= 16'd0;
			prod_q    <= 16'd0;
			inten_q   <= 8'd0;
			emit_q    <= 5'd0;
			ov_q      <= 1'b0;
			byte_q    <= 8'd0;
			last_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= (state_nxt != state_q) ? 6'd0 : cnt_q + 6'd1;
			if (pop && head.kind == CMD_COMMIT) begin
				sel_q     <= !sel_q;
				pending_q <= 1'b1;
			end
			if (pop && head.kind == CMD_TICK) begin
				elapsed_q <= elapsed_n;
				changed_q <= 1'b0;
				nonzero_q <= 1'b0;
				max_q     <= 8'd0;
				g1_q      <= 16'd0;
				g2_q      <= 16'd0;
				g3_q      <= 16'd0;
				g4_q      <= 16'd0;
			end
			if (state_q == BK_SCAN && proc_ok) begin
				if (cur_val != sent_val) changed_q <= 1'b1;
				if (cur_val > max_q) max_q <= cur_val;
				if (cur_val != 8'd0) begin
					nonzero_q <= 1'b1;
					if (pi < 6'(HALF_COUNT)) begin
						if (k[1]) g4_q <= g4_q | gate_bit(k);
						else g1_q <= g1_q | gate_bit(k);
					end else begin
						if (k[1]) g3_q <= g3_q | gate_bit(k);
						else g2_q <= g2_q | gate_bit(k);
					end
				end
			end
			if (state_q == BK_DECIDE && send) elapsed_q <= 10'd0;
			if (state_q == BK_MUL) prod_q <= 16'(max_q) * 16'd255;
			if (state_q == BK_DIV) inten_q <= quot_full[RECIP_SH +: 8];
			if (state_q != BK_EMIT) emit_q <= 5'd0;
			// Output register: load the next frame byte, or drop a taken one.
			if (out_ready) begin
				if (state_q == BK_EMIT) begin
					ov_q   <= 1'b1;
					byte_q <= frame_at(emit_q, cfg.pulse, inten_q, g1_q, g2_q, g3_q, g4_q);
					last_q <= (emit_q == 5'(FRAME_LEN - 1));
					emit_q <= emit_q + 5'd1;
				end else begin
					ov_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid  = ov_q;
	assign frame_byte = byte_q;
	assign frame_last = last_q;

	`MFB_ASSERT_NEXT(a_gap_after_last, out_valid && frame_last && !out_stall, !out_valid, "frame bytes run past the last one")
	`MFB_ASSERT_SAME(a_emit_clears_elapsed, state_q == BK_EMIT, elapsed_q == 10'd0, "elapsed count not cleared for a sent frame")
endmodule
